>>> sv/etc1td_pkg.sv
package etc1td_pkg;

    localparam int ADDR_W = 3;

    // Register word index (paddr[2]) of the alpha enable register.
    localparam logic REG_ALPHA_EN = 1'b0;

    typedef struct packed {
        logic ld2;
        logic ld3;
    } pipe_ctl_t;

    // Modifier magnitude by table index and per-texel sub-index bit.
    function automatic logic [7:0] mod_mag(input logic [2:0] tidx, input logic sub);
        logic [7:0] lo;
        logic [7:0] hi;
        begin
            case (tidx)
                3'd0: begin lo = 8'd2;  hi = 8'd8;   end
                3'd1: begin lo = 8'd5;  hi = 8'd17;  end
                3'd2: begin lo = 8'd9;  hi = 8'd29;  end
                3'd3: begin lo = 8'd13; hi = 8'd42;  end
                3'd4: begin lo = 8'd18; hi = 8'd60;  end
                3'd5: begin lo = 8'd24; hi = 8'd80;  end
                3'd6: begin lo = 8'd33; hi = 8'd106; end
                default: begin lo = 8'd47; hi = 8'd183; end
            endcase
            mod_mag = sub ? hi : lo;
        end
    endfunction

    function automatic logic [7:0] expand4(input logic [3:0] v);
        expand4 = {v, v};
    endfunction

    function automatic logic [7:0] expand5(input logic [4:0] v);
        expand5 = {v, v[4:2]};
    endfunction

endpackage

>>> sv/etc1td_chan.sv
module etc1td_chan (
    input  logic                  aclk,
    input  etc1td_pkg::pipe_ctl_t ctl,
    input  logic                  diff,
    input  logic                  second,
    input  logic [7:0]            field,
    input  logic signed [8:0]     modifier,
    output logic [7:0]            chan
);
    import etc1td_pkg::*;

    logic [4:0]        diff_base;
    logic [7:0]        exp_next;
    logic [7:0]        exp_reg;
    logic signed [9:0] sum;
    logic [7:0]        clamp_next;
    logic [7:0]        chan_reg;

    // Differential second sub-block: base plus signed delta, wrapped to 5 bits.
    assign diff_base = second ? (field[7:3] + {{2{field[2]}}, field[2:0]}) : field[7:3];

    always_comb begin
        if (diff) begin
            exp_next = expand5(diff_base);
        end else begin
            exp_next = expand4(second ? field[3:0] : field[7:4]);
        end
    end

    assign sum = $signed({2'b00, exp_reg}) + {modifier[8], modifier};

    always_comb begin
        if (sum[9]) begin
            clamp_next = 8'd0;
        end else if (sum[8]) begin
            clamp_next = 8'hFF;
        end else begin
            clamp_next = sum[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld2) begin
            exp_reg <= exp_next;
        end
        if (ctl.ld3) begin
            chan_reg <= clamp_next;
        end
    end

    assign chan = chan_reg;

endmodule

>>> sv/etc1_texel_decoder_top.sv
// ETC1 texel decoder with optional 4-bit alpha.
// Input channel (s_*): one 64-bit ETC1 color block, a 64-bit word of sixteen
// alpha nibbles and a texel column/row. Result channel (m_*): that texel's
// 8-bit red, green, blue and alpha.
// Three register stages: texel select and field decode, base expansion and
// modifier lookup, then modifier add with clamp into the output register.
// Throughput is one texel per clock while the receiver keeps m_ready high;
// texels are independent.
// When the receiver holds m_ready low, stages fill from the output back; a
// stage takes new data only when it is empty or moving on, so nothing is lost
// or repeated. s_ready drops only once all three stages hold a texel.
// APB register 0 (byte address 0): bit 0 alpha_enable; 0 gives alpha 255.
// Write it only while no texel is in flight.
// Reset (aresetn low, synchronous) empties the pipeline and clears
// alpha_enable.
module etc1_texel_decoder_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [etc1td_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [63:0]                   s_color_block,
    input  logic [63:0]                   s_alpha_block,
    input  logic [1:0]                    s_texel_col,
    input  logic [1:0]                    s_texel_row,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_red,
    output logic [7:0]                    m_green,
    output logic [7:0]                    m_blue,
    output logic [7:0]                    m_alpha
);
    import etc1td_pkg::*;

    logic alpha_en_reg;

    logic v1_reg, v2_reg, v3_reg;
    logic v1_next, v2_next, v3_next;
    logic adv1, adv2, adv3;
    pipe_ctl_t ctl;

    // Stage 1 decode
    logic [3:0]  texel;
    logic        second;
    logic [3:0]  nib;

    logic        diff1_reg;
    logic        second1_reg;
    logic [23:0] bases1_reg;
    logic [2:0]  tidx1_reg;
    logic        sub1_reg;
    logic        neg1_reg;
    logic [7:0]  alpha1_reg;

    // Stage 2
    logic signed [8:0] mod2_reg;
    logic [7:0]        alpha2_reg;
    logic [7:0]        mag;
    logic [7:0]        alpha3_reg;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ALPHA_EN) ? {31'd0, alpha_en_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_en_reg <= 1'b0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_ALPHA_EN)) begin
            alpha_en_reg <= pwdata[0];
        end
    end

    // Pipeline flow control
    assign adv3 = !v3_reg || m_ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign s_ready = adv1;
    assign ctl.ld2 = adv2 && v1_reg;
    assign ctl.ld3 = adv3 && v2_reg;

    always_comb begin
        v1_next = adv1 ? s_valid : v1_reg;
        v2_next = adv2 ? v1_reg : v2_reg;
        v3_next = adv3 ? v2_reg : v3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Stage 1: pick the texel's bits out of the block
    assign texel  = {s_texel_col, s_texel_row};
    assign second = s_color_block[32] ? s_texel_row[1] : s_texel_col[1];
    assign nib    = s_alpha_block[{texel, 2'b00} +: 4];

    always_ff @(posedge aclk) begin
        if (adv1 && s_valid) begin
            diff1_reg   <= s_color_block[33];
            second1_reg <= second;
            bases1_reg  <= s_color_block[63:40];
            tidx1_reg   <= second ? s_color_block[36:34] : s_color_block[39:37];
            sub1_reg    <= s_color_block[{2'b00, texel}];
            // negation flags sit at bit 16 + texel
            neg1_reg    <= s_color_block[{2'b01, texel}];
            alpha1_reg  <= alpha_en_reg ? {nib, nib} : 8'hFF;
        end
    end

    // Stage 2: modifier lookup (channel expansion lives in the channel units)
    assign mag = mod_mag(tidx1_reg, sub1_reg);

    always_ff @(posedge aclk) begin
        if (ctl.ld2) begin
            mod2_reg   <= neg1_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            alpha2_reg <= alpha1_reg;
        end
        if (ctl.ld3) begin
            alpha3_reg <= alpha2_reg;
        end
    end

    etc1td_chan u_red (
        .aclk     (aclk),
        .ctl      (ctl),
        .diff     (diff1_reg),
        .second   (second1_reg),
        .field    (bases1_reg[23:16]),
        .modifier (mod2_reg),
        .chan     (m_red)
    );

    etc1td_chan u_green (
        .aclk     (aclk),
        .ctl      (ctl),
        .diff     (diff1_reg),
        .second   (second1_reg),
        .field    (bases1_reg[15:8]),
        .modifier (mod2_reg),
        .chan     (m_green)
    );

    etc1td_chan u_blue (
        .aclk     (aclk),
        .ctl      (ctl),
        .diff     (diff1_reg),
        .second   (second1_reg),
        .field    (bases1_reg[7:0]),
        .modifier (mod2_reg),
        .chan     (m_blue)
    );

    assign m_alpha = alpha3_reg;
    assign m_valid = v3_reg;

`ifndef NO_ASSERTIONS
    // A new result only appears when stage 2 held a texel the cycle before.
    a_out_from_s2: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(v3_reg) |-> $past(v2_reg))
        else $error("output valid without stage 2 data");

    // Back-pressure only when every stage is occupied and the output is stalled.
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && v3_reg && !m_ready))
        else $error("input stalled with room in the pipeline");

    // A stage-2 texel that cannot move on is kept.
    a_s2_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && !ctl.ld3) |=> v2_reg)
        else $error("stage 2 texel dropped");

    // A stage-1 texel is kept until stage 2 takes it.
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !ctl.ld2) |=> v1_reg)
        else $error("stage 1 texel dropped");
`endif

endmodule
